// ===== rtl/core/encp_pkg.sv =====
// encp_pkg: shared types and constants for the encoder period capture block
// no dependencies; used by encp_lane, encp_merge and the top level
`timescale 1ns / 1ps
`default_nettype none

package encp_pkg;

  // maximum lane count of the capture unit and result field widths
  localparam int MAX_LANES   = 4;
  localparam int CHAN_BITS   = 2;
  localparam int PERIOD_BITS = 24;

  // what one capture lane reports for the current tick
  typedef struct packed {
    logic                   rise;
    logic                   dir;
    logic [PERIOD_BITS-1:0] period;
  } encp_lane_res_t;

endpackage : encp_pkg

`default_nettype wire

// ===== rtl/core/encp_lane.sv =====
// encp_lane: one capture channel, edge detect, wrap counter and period math
// depends on encp_pkg
`timescale 1ns / 1ps
`default_nettype none

module encp_lane
  import encp_pkg::*;
#(
  parameter int TIMER_BITS = 16,
  parameter int WRAP_BITS  = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  accept,
  input  wire logic                  a_level,
  input  wire logic                  b_level,
  input  wire logic [TIMER_BITS-1:0] timer_nxt,
  input  wire logic                  timer_wrap,
  output encp_lane_res_t             res
);

  localparam int FULL_BITS = TIMER_BITS + WRAP_BITS;
  localparam int SPAN_BITS = (FULL_BITS > PERIOD_BITS) ? FULL_BITS : PERIOD_BITS;

  logic                  prev_a_r;
  logic [TIMER_BITS-1:0] capture_r;
  logic [WRAP_BITS-1:0]  wrap_r;
  logic [WRAP_BITS-1:0]  wrap_cur;
  logic [SPAN_BITS-1:0]  span;
  logic                  rise;

  // wrap count as seen after this tick's timer advance
  assign wrap_cur = timer_wrap ? (wrap_r + WRAP_BITS'(1)) : wrap_r;
  assign rise     = a_level & ~prev_a_r;

  // ticks since the previous capture, modulo the result width
  assign span = SPAN_BITS'({wrap_cur, timer_nxt}) - SPAN_BITS'(capture_r);

  assign res.rise   = rise;
  assign res.dir    = b_level;
  assign res.period = span[PERIOD_BITS-1:0];

  // lane state updates once per accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_a_r  <= 1'b0;
      capture_r <= '0;
      wrap_r    <= '0;
    end else if (accept) begin
      prev_a_r <= a_level;
      if (rise) begin
        capture_r <= timer_nxt;
        wrap_r    <= '0;
      end else begin
        wrap_r <= wrap_cur;
      end
    end
  end

endmodule : encp_lane

`default_nettype wire

// ===== rtl/core/encp_merge.sv =====
// encp_merge: holds the lane results of one tick and serializes them
// onto the result stream, lowest channel first; depends on encp_pkg
`timescale 1ns / 1ps
`default_nettype none

module encp_merge
  import encp_pkg::*;
(
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            load,
  input  wire encp_lane_res_t [MAX_LANES-1:0]  lane_res,
  output logic                                 load_ready,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [CHAN_BITS-1:0]                 out_chan,
  output logic [PERIOD_BITS-1:0]               out_period,
  output logic                                 out_dir,
  output logic                                 out_last
);

  logic [MAX_LANES-1:0]                 pend_r, pend_nxt;
  encp_lane_res_t [MAX_LANES-1:0]       pend_data_r;
  logic [CHAN_BITS-1:0]                 sel_idx;
  logic [MAX_LANES-1:0]                 pick;
  logic [MAX_LANES-1:0]                 remain;
  logic                                 move;
  logic                                 out_valid_r;
  logic [CHAN_BITS-1:0]                 out_chan_r;
  logic [PERIOD_BITS-1:0]               out_period_r;
  logic                                 out_dir_r;
  logic                                 out_last_r;

  // lowest pending channel wins
  always_comb begin
    sel_idx = '0;
    for (int i = MAX_LANES - 1; i >= 0; i--) begin
      if (pend_r[i]) begin
        sel_idx = CHAN_BITS'(i);
      end
    end
  end

  assign pick   = MAX_LANES'(1) << sel_idx;
  assign remain = pend_r & ~pick;
  assign move   = (pend_r != '0) && (!out_valid_r || out_ready);

  assign load_ready = (pend_r == '0);

  // pending mask: loaded per tick, one bit retired per move
  always_comb begin
    pend_nxt = pend_r;
    if (load) begin
      for (int i = 0; i < MAX_LANES; i++) begin
        pend_nxt[i] = lane_res[i].rise;
      end
    end else if (move) begin
      pend_nxt = remain;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // pending payload
  always_ff @(posedge clk) begin
    if (load) begin
      pend_data_r <= lane_res;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_chan_r   <= sel_idx;
      out_period_r <= pend_data_r[sel_idx].period;
      out_dir_r    <= pend_data_r[sel_idx].dir;
      out_last_r   <= (remain == '0);
    end
  end

  assign out_valid  = out_valid_r;
  assign out_chan   = out_chan_r;
  assign out_period = out_period_r;
  assign out_dir    = out_dir_r;
  assign out_last   = out_last_r;

`ifndef SYNTH
  // taking the final result of a tick empties the pending mask
  assert property (@(posedge clk) disable iff (!rst_n)
    (move && (remain == '0)) |=> (pend_r == '0))
    else $error("pending mask not empty after final result");

  // pending results always lead to a valid output next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r != '0) |=> out_valid_r)
    else $error("pending results but no output");

  // a new tick is only loaded over an empty pending mask
  assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (pend_r == '0) && !move)
    else $error("tick loaded while results pending");
`endif

endmodule : encp_merge

`default_nettype wire

// ===== rtl/core/encoder_period_capture_top.sv =====
// encoder_period_capture_top: shared timer, capture lanes and result merge
// depends on encp_pkg, encp_lane, encp_merge
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  fields
// in_      in   tdata: a_levels[3:0], b_levels[7:4]
// out_     out  tdata: channel[1:0], period[25:2], direction[26]; tlast: last
//
// a tick with no rising A edge is taken every cycle while nothing is pending; a tick
// with edges is loaded, then moves one result per cycle, unless the output stalls,
// into the single result register
// the next tick is taken once the previous tick's results have all moved
// into the output register, so a stalled output holds off input
// synchronous active-low reset clears timer, lane state and all valids

module encoder_period_capture_top
  import encp_pkg::*;
#(
  parameter int CHANNELS   = 4,
  parameter int TIMER_BITS = 16,
  parameter int WRAP_BITS  = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // a_levels[3:0], b_levels[7:4]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // channel[1:0], period[25:2], direction[26]
  output logic             out_tlast   // last
);

  localparam int LANES = (CHANNELS < MAX_LANES) ? CHANNELS : MAX_LANES;

  logic [TIMER_BITS-1:0]          timer_r;
  logic [TIMER_BITS-1:0]          timer_nxt;
  logic                           timer_wrap;
  logic                           accept;
  logic [MAX_LANES-1:0]           a_levels;
  logic [MAX_LANES-1:0]           b_levels;
  encp_lane_res_t [MAX_LANES-1:0] lane_res;
  logic [CHAN_BITS-1:0]           res_chan;
  logic [PERIOD_BITS-1:0]         res_period;
  logic                           res_dir;

  assign a_levels = in_tdata[3:0];
  assign b_levels = in_tdata[7:4];
  assign accept   = in_tvalid && in_tready;

  // shared free-running timer, advanced by each tick
  assign timer_nxt  = timer_r + TIMER_BITS'(1);
  assign timer_wrap = (timer_nxt == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_r <= '0;
    end else if (accept) begin
      timer_r <= timer_nxt;
    end
  end

  // capture lanes, missing channels report nothing
  for (genvar g = 0; g < MAX_LANES; g++) begin : g_lane
    if (g < LANES) begin : g_on
      encp_lane #(
        .TIMER_BITS (TIMER_BITS),
        .WRAP_BITS  (WRAP_BITS)
      ) u_lane (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .a_level    (a_levels[g]),
        .b_level    (b_levels[g]),
        .timer_nxt  (timer_nxt),
        .timer_wrap (timer_wrap),
        .res        (lane_res[g])
      );
    end else begin : g_off
      assign lane_res[g] = '0;
    end
  end

  // serialize the tick's results
  encp_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept),
    .lane_res   (lane_res),
    .load_ready (in_tready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_chan   (res_chan),
    .out_period (res_period),
    .out_dir    (res_dir),
    .out_last   (out_tlast)
  );

  assign out_tdata = {5'b0, res_dir, res_period, res_chan};

endmodule : encoder_period_capture_top

`default_nettype wire

// ===== sim/tb_top.sv =====
// tb_top: self-checking testbench for encoder_period_capture_top
// depends on encp_pkg and the encoder period capture rtl; stream driver and monitor
`timescale 1ns / 1ps

module tb_top;
  import encp_pkg::*;

  localparam int IDLE_PCT     = 22;
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_TICKS  = 24;
  localparam int RANDOM_TICKS = 360;
  localparam int DRAIN_MAX    = 5000;
  localparam int END_WAIT     = 16;

  // one expected capture, same field order as the result stream
  typedef struct packed {
    logic [CHAN_BITS-1:0]   channel;
    logic [PERIOD_BITS-1:0] period;
    logic                   direction;
    logic                   is_last;
  } capture_t;

  // one pending timer tick and whether it falls in the no-idle stretch
  typedef struct {
    logic [7:0] data;
    bit         steady;
  } tick_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [7:0]  in_tdata   = '0;   // a_levels[3:0], b_levels[7:4]
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [31:0] out_tdata;         // channel[1:0], period[25:2], direction[26]
  logic        out_tlast;         // last

  // shadow state of the capture unit
  logic [15:0] timer_q  = '0;
  logic [3:0]  prev_a_q = '0;
  logic [15:0] cap_q   [MAX_LANES] = '{default: '0};
  logic [7:0]  wraps_q [MAX_LANES] = '{default: '0};

  tick_t    pending_q[$];
  capture_t expected_q[$];

  int ticks_taken  = 0;
  int n_predicted  = 0;
  int n_checked    = 0;
  int n_errors     = 0;
  int total_ticks  = 0;
  int hold_at      = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;
  bit steady_now   = 1'b0;
  int cycle_cnt    = 0;
  int cycle_limit  = 0;
  int edges [MAX_LANES] = '{default: 0};

  encoder_period_capture_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // advance the shadow timer by one tick and queue the captures it causes
  function automatic int predict_tick(input logic [7:0] d);
    logic [3:0]  a_lv;
    logic [3:0]  b_lv;
    logic [3:0]  rising;
    logic [31:0] span;
    capture_t    c;
    int          n;
    n = 0;
    a_lv = d[3:0];
    b_lv = d[7:4];
    timer_q = timer_q + 16'd1;
    if (timer_q == 16'd0) begin
      for (int i = 0; i < MAX_LANES; i++) wraps_q[i] = wraps_q[i] + 8'd1;
    end
    rising = a_lv & ~prev_a_q;
    prev_a_q = a_lv;
    for (int i = 0; i < MAX_LANES; i++) begin
      if (rising[i]) begin
        span = {16'd0, timer_q} + {8'd0, wraps_q[i], 16'd0} - {16'd0, cap_q[i]};
        c.channel   = CHAN_BITS'(i);
        c.period    = span[PERIOD_BITS-1:0];
        c.direction = b_lv[i];
        c.is_last   = ((rising >> (i + 1)) == 4'd0);
        expected_q.push_back(c);
        cap_q[i]   = timer_q;
        wraps_q[i] = '0;
        edges[i]++;
        n++;
      end
    end
    return n;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    n_errors++;
  endtask

  task automatic add_tick(input logic [3:0] a_lv, input logic [3:0] b_lv, input bit s);
    tick_t t;
    t.data   = {b_lv, a_lv};
    t.steady = s;
    pending_q.push_back(t);
  endtask

  // input driver: one tick per transaction, random gaps outside the steady stretch
  always @(posedge clk) begin : drive_ticks
    tick_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        n_predicted <= n_predicted + predict_tick(in_tdata);
        ticks_taken <= ticks_taken + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_q.size() > 0 &&
            (pending_q[0].steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          nxt = pending_q.pop_front();
          in_tvalid  <= 1'b1;
          in_tdata   <= nxt.data;
          steady_now <= nxt.steady;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, so the block backs up and stalls its input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && hold_at > 0 && ticks_taken >= hold_at) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor: compare each transaction with the oldest expected capture
  always @(posedge clk) begin : check_results
    capture_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        n_checked <= n_checked + 1;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", out_tdata, 0);
        end else begin
          want = expected_q.pop_front();
          if (out_tdata[1:0] !== want.channel)
            report_mismatch("channel", out_tdata[1:0], want.channel);
          if (out_tdata[25:2] !== want.period)
            report_mismatch("period", out_tdata[25:2], want.period);
          if (out_tdata[26] !== want.direction)
            report_mismatch("direction", out_tdata[26], want.direction);
          if (out_tlast !== want.is_last)
            report_mismatch("last", out_tlast, want.is_last);
        end
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
      end else if (steady_now) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // watchdog
  initial begin
    wait (cycle_limit != 0);
    while (cycle_cnt < cycle_limit) @(posedge clk);
    $display("timeout after %0d cycles", cycle_cnt);
    $display("*** FAILED ***");
    $finish;
  end

  // stimulus, reset and end of run
  initial begin
    int          run;
    int          drain;
    bit          st;
    logic [3:0]  a_r;
    logic [3:0]  b_r;

    // directed: first edges after reset, all channels at once, single lanes,
    // held lines that must not retrigger, b changes without an edge
    add_tick(4'hF, 4'hF, 1'b0);
    add_tick(4'h0, 4'h0, 1'b0);
    add_tick(4'hF, 4'h0, 1'b0);
    add_tick(4'h0, 4'hF, 1'b0);
    add_tick(4'h1, 4'h0, 1'b0);
    add_tick(4'h0, 4'h0, 1'b0);
    add_tick(4'h2, 4'h2, 1'b0);
    add_tick(4'h4, 4'h4, 1'b0);
    add_tick(4'h8, 4'h0, 1'b0);
    add_tick(4'hC, 4'hC, 1'b0);
    add_tick(4'h3, 4'hA, 1'b0);
    add_tick(4'h0, 4'h0, 1'b0);
    add_tick(4'h5, 4'hA, 1'b0);
    add_tick(4'hA, 4'h5, 1'b0);
    add_tick(4'hF, 4'hF, 1'b0);
    add_tick(4'hF, 4'h0, 1'b0);
    add_tick(4'h0, 4'hF, 1'b0);

    // short quiet stretch, then every channel fires
    for (int k = 0; k < QUIET_TICKS; k++) add_tick(4'h0, 4'($urandom), 1'b0);
    add_tick(4'hF, 4'($urandom), 1'b0);

    // random lines, with held stretches that stretch the periods
    a_r = 4'hF;
    for (int k = 0; k < RANDOM_TICKS; k++) begin
      if (k == 320) hold_at = pending_q.size();
      a_r = 4'($urandom_range(0, 15));
      b_r = 4'($urandom_range(0, 15));
      st  = (k >= 150 && k < 250);
      add_tick(a_r, b_r, st);
      if ($urandom_range(0, 39) == 0) begin
        run = $urandom_range(3, 12);
        for (int j = 0; j < run; j++) add_tick(a_r, 4'($urandom), st);
      end
    end
    total_ticks = pending_q.size();
    cycle_limit = 4 * total_ticks + 200000;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // all ticks in, then let the captures drain
    while (ticks_taken != total_ticks) @(posedge clk);
    drain = 0;
    while (n_checked < n_predicted && drain < DRAIN_MAX) begin
      @(posedge clk);
      drain++;
    end
    repeat (END_WAIT) @(posedge clk);
    if (n_checked < n_predicted)
      report_mismatch("captures never delivered", n_checked, n_predicted);

    $display("ran %0d timer ticks: directed edges, random lines and a no-idle stretch",
             total_ticks);
    $display("checked %0d captures; edges per channel %0d %0d %0d %0d; one %0d-cycle hold",
             n_checked, edges[0], edges[1], edges[2], edges[3], HOLD_CYCLES);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== encoder_period_capture_top.f =====
rtl/core/encp_pkg.sv
rtl/core/encp_lane.sv
rtl/core/encp_merge.sv
rtl/core/encoder_period_capture_top.sv
sim/tb_top.sv
